@@ design/dempc_pkg.sv @@
// Package for the two-wheel move controller: transaction types, codes and constants.
// Depends on nothing; used by dempc_side and dual_encoder_motor_pwm_controller.
package dempc_pkg;

   localparam int DEF_PWM_PERIOD = 64;
   localparam int START_DUTY     = 32;
   localparam int WARM_EDGES     = 4;
   localparam int STALL_TICKS    = 4096;
   localparam int SLOW_STEPS     = 32;
   localparam int SLOW_BASE      = 64;
   localparam int SPEED_BASE     = 40;

   localparam int CMD_W    = 24;
   localparam int COUNT_W  = 16;
   localparam int TICK_W   = 13;
   localparam int SPEED_W  = 16;
   localparam int TARGET_W = 10;
   localparam int TR_W     = 4;
   localparam int RR_W     = 8;

   typedef enum logic {
      MODE_CMD  = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_IDLE   = 2'd0,
      STATUS_RUN    = 2'd1,
      STATUS_REJECT = 2'd2,
      STATUS_FIN    = 2'd3
   } status_type;

   typedef struct packed {
      logic             mode;
      logic [CMD_W-1:0] command;
      logic             enc_right;
      logic             enc_left;
   } req_type;

   typedef struct packed {
      logic       drive_right;
      logic       drive_left;
      logic [1:0] status;
   } rsp_type;

   // Per-wheel control from the top level
   typedef struct packed {
      logic start;
      logic tick;
      logic period_end;
   } side_ctrl_type;

   // Per-wheel results of the current tick
   typedef struct packed {
      logic drive;
      logic done;
   } side_stat_type;

endpackage

@@ design/dempc_side.sv @@
// One wheel of the move controller: encoder edge timing, slowdown, duty control, stall.
// Depends on dempc_pkg.
module dempc_side
   import dempc_pkg::*;
#(
   parameter int PWM_PERIOD = DEF_PWM_PERIOD,
   localparam int PHASE_W = $clog2(PWM_PERIOD)
) (
   input  logic                clock,
   input  logic                reset,
   input  side_ctrl_type       ctrl,
   input  logic                enc,
   input  logic [TR_W-1:0]     speed_field,
   input  logic [RR_W-1:0]     rot_field,
   input  logic [PHASE_W-1:0]  phase,
   output side_stat_type       stat
);

   localparam int DUTY_MAX = (PWM_PERIOD > START_DUTY) ? PWM_PERIOD : START_DUTY;
   localparam int DUTY_W   = $clog2(DUTY_MAX + 1);
   localparam int CMP_W    = (DUTY_W > PHASE_W) ? DUTY_W : PHASE_W;
   localparam int DIFF_W   = SPEED_W + 2;

   logic                prev_enc_ff, prev_enc_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TICK_W-1:0]   ticks_ff, ticks_in;
   logic [TICK_W-1:0]   prev_int_ff, prev_int_in;
   logic [SPEED_W-1:0]  delta_ff, delta_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;

   logic                rise;
   logic [COUNT_W-1:0]  count_e;
   logic [TICK_W-1:0]   ticks_e;
   logic [COUNT_W-1:0]  target_x;
   logic                warm;
   logic [SPEED_W-1:0]  steps, slow_i, bound;
   logic signed [DIFF_W-1:0] diff, tgt, delta_x;

   always_comb begin
      rise     = enc & ~prev_enc_ff;
      target_x = COUNT_W'(target_ff);
      count_e  = rise ? count_ff + 1'b1 : count_ff;
      ticks_e  = rise ? '0 : ticks_ff + 1'b1;

      prev_enc_in = prev_enc_ff;
      count_in    = count_ff;
      ticks_in    = ticks_ff;
      prev_int_in = prev_int_ff;
      delta_in    = delta_ff;
      speed_in    = speed_ff;
      target_in   = target_ff;
      duty_in     = duty_ff;

      warm   = count_e >= COUNT_W'(WARM_EDGES);
      steps  = target_x - count_e;
      slow_i = SPEED_W'(SLOW_STEPS) - steps;
      bound  = SPEED_W'(SLOW_BASE) + {slow_i[SPEED_W-3:0], 2'b00};
      diff   = '0;
      tgt    = '0;
      delta_x = DIFF_W'($signed(delta_ff));
      stat.drive = 1'b0;
      stat.done  = 1'b0;

      if (ctrl.start) begin
         prev_enc_in = enc;
         count_in    = '0;
         ticks_in    = '0;
         prev_int_in = '0;
         delta_in    = '0;
         duty_in     = DUTY_W'(START_DUTY);
         speed_in    = SPEED_W'(SPEED_BASE) + {{(SPEED_W-TR_W-3){1'b0}}, speed_field, 3'b000};
         target_in   = {rot_field, 2'b00};
      end else if (ctrl.tick) begin
         prev_enc_in = enc;
         count_in    = count_e;
         ticks_in    = ticks_e;
         if (rise) begin
            prev_int_in = ticks_ff;
            delta_in    = SPEED_W'($signed({1'b0, ticks_ff}) - $signed({1'b0, prev_int_ff}));
         end
         // Raise the interval target over the last steps before the target
         if ($signed(steps) <= $signed(SPEED_W'(SLOW_STEPS)) && $signed(bound) > $signed(speed_ff))
            speed_in = bound;

         stat.drive = (CMP_W'(phase) < CMP_W'(duty_ff)) && (count_e < target_x);

         // Nudge duty toward the wanted interval change, truncating toward zero
         diff    = DIFF_W'($signed(speed_in)) - $signed(DIFF_W'(prev_int_in));
         tgt     = diff[DIFF_W-1] ? (diff + DIFF_W'(3)) >>> 2 : diff >>> 2;
         delta_x = DIFF_W'($signed(delta_in));
         if (ctrl.period_end && warm) begin
            if (delta_x < tgt && duty_ff > DUTY_W'(1))
               duty_in = duty_ff - 1'b1;
            if (delta_x > tgt && duty_ff < DUTY_W'(PWM_PERIOD))
               duty_in = duty_ff + 1'b1;
         end

         if (ticks_e >= TICK_W'(STALL_TICKS)) begin
            ticks_in = TICK_W'(STALL_TICKS);
            count_in = target_x;
         end
         stat.done = count_in >= target_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_enc_ff <= 1'b0;
         count_ff    <= '0;
         ticks_ff    <= '0;
         prev_int_ff <= '0;
         delta_ff    <= '0;
         speed_ff    <= '0;
         target_ff   <= '0;
         duty_ff     <= DUTY_W'(START_DUTY);
      end else begin
         prev_enc_ff <= prev_enc_in;
         count_ff    <= count_in;
         ticks_ff    <= ticks_in;
         prev_int_ff <= prev_int_in;
         delta_ff    <= delta_in;
         speed_ff    <= speed_in;
         target_ff   <= target_in;
         duty_ff     <= duty_in;
      end
   end

endmodule

@@ design/dual_encoder_motor_pwm_controller.sv @@
// Top level of the two-wheel move controller with software PWM and encoder feedback.
// Depends on dempc_pkg and dempc_side.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_stall  | req_type: mode, command, enc_right, enc_left
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_type: drive_right, drive_left, status
//
// For each transaction the wheel logic updates its state and the
// result lands in the rsp register at the same edge. One transaction per cycle is
// sustained while no result waits under rsp_stall; the only loop is the state update of each wheel.
// Reset (synchronous, active high) clears the run, both wheels and rsp_valid, but not the rsp payload.
// While rsp_stall holds a waiting result, req_stall rises; a taken result frees the
// register for a new transaction in the same cycle.
module dual_encoder_motor_pwm_controller
   import dempc_pkg::*;
#(
   parameter int PWM_PERIOD = DEF_PWM_PERIOD
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int PHASE_W = $clog2(PWM_PERIOD);

   logic               running_ff, running_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [1:0]         drive_ff, drive_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic          accept;
   logic          reject;
   side_ctrl_type ctrl;
   side_stat_type stat_r, stat_l;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Reject a command whose rotation target (4 * field) is 4 or less
   assign reject = (req_payload.command[19:12] <= RR_W'(1))
                 | (req_payload.command[7:0] <= RR_W'(1));

   always_comb begin
      ctrl.start      = accept && (req_payload.mode == MODE_CMD) && !running_ff && !reject;
      ctrl.tick       = accept && (req_payload.mode == MODE_TICK) && running_ff;
      ctrl.period_end = phase_ff == PHASE_W'(PWM_PERIOD - 1);
   end

   dempc_side #(.PWM_PERIOD(PWM_PERIOD)) u_side_right (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .enc         (req_payload.enc_right),
      .speed_field (req_payload.command[23:20]),
      .rot_field   (req_payload.command[19:12]),
      .phase       (phase_ff),
      .stat        (stat_r)
   );

   dempc_side #(.PWM_PERIOD(PWM_PERIOD)) u_side_left (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .enc         (req_payload.enc_left),
      .speed_field (req_payload.command[11:8]),
      .rot_field   (req_payload.command[7:0]),
      .phase       (phase_ff),
      .stat        (stat_l)
   );

   always_comb begin
      running_in = running_ff;
      phase_in   = phase_ff;
      drive_in   = drive_ff;
      rsp_in     = rsp_ff;
      // Hold a result the sink has not taken; drop it once taken
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_payload.mode)
            MODE_CMD: begin
               if (running_ff) begin
                  // Ignore the command; repeat the last drive levels
                  rsp_in = '{drive_right: drive_ff[0], drive_left: drive_ff[1],
                             status: STATUS_RUN};
               end else if (reject) begin
                  rsp_in = '{drive_right: 1'b0, drive_left: 1'b0, status: STATUS_REJECT};
               end else begin
                  running_in = 1'b1;
                  phase_in   = '0;
                  drive_in   = 2'b11;
                  rsp_in     = '{drive_right: 1'b1, drive_left: 1'b1, status: STATUS_RUN};
               end
            end
            MODE_TICK: begin
               if (!running_ff) begin
                  rsp_in = '{drive_right: 1'b0, drive_left: 1'b0, status: STATUS_IDLE};
               end else begin
                  // Advance the PWM phase, wrapping at the period end
                  phase_in = ctrl.period_end ? '0 : phase_ff + 1'b1;
                  if (stat_r.done && stat_l.done) begin
                     running_in = 1'b0;
                     drive_in   = 2'b00;
                     rsp_in     = '{drive_right: 1'b0, drive_left: 1'b0, status: STATUS_FIN};
                  end else begin
                     drive_in = {stat_l.drive, stat_r.drive};
                     rsp_in   = '{drive_right: stat_r.drive, drive_left: stat_l.drive,
                                  status: STATUS_RUN};
                  end
               end
            end
            default: begin
               rsp_in = '{drive_right: 1'b0, drive_left: 1'b0, status: STATUS_IDLE};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         phase_ff     <= '0;
         drive_ff     <= 2'b00;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         phase_ff     <= phase_in;
         drive_ff     <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // A result other than running never drives a motor
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != STATUS_RUN) |-> !rsp_ff.drive_right && !rsp_ff.drive_left)
      else $error("motor driven outside a run");

   // A run ends only through a finished result
   assert property (@(posedge clock) disable iff (reset)
      $fell(running_ff) && !$past(reset) |-> rsp_valid_ff && (rsp_ff.status == STATUS_FIN))
      else $error("run ended without a finished result");

   // Idle, rejected and finished results leave no run active
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == STATUS_IDLE || rsp_ff.status == STATUS_REJECT ||
                       rsp_ff.status == STATUS_FIN) |-> !running_ff)
      else $error("run active after an idle, rejected or finished result");

endmodule

@@ verif/dempc_checker.sv @@
// Checker for the two-wheel move controller: watches the req and rsp channels,
// predicts every result and compares it field by field. Depends on dempc_pkg.
module dempc_checker
   import dempc_pkg::*;
#(
   parameter int PERIOD = DEF_PWM_PERIOD
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      errors,
   output int      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Predicted controller state; index 0 is the right wheel, 1 the left
   logic               moving;
   logic               enc_seen     [2];
   logic [15:0]        edges_done   [2];
   logic [12:0]        since_edge   [2];
   logic [12:0]        last_period  [2];
   logic signed [15:0] period_delta [2];
   logic signed [15:0] pace         [2];
   logic [15:0]        edges_goal   [2];
   logic [6:0]         duty_lvl     [2];
   logic               drive_lvl    [2];
   int                 phase;

   rsp_type due_results [$];
   int      fail_tally = 0;

   function automatic void clear_motion();
      moving = 1'b0;
      phase  = 0;
      for (int s = 0; s < 2; s++) begin
         enc_seen[s]     = 1'b0;
         edges_done[s]   = '0;
         since_edge[s]   = '0;
         last_period[s]  = '0;
         period_delta[s] = '0;
         pace[s]         = '0;
         edges_goal[s]   = '0;
         duty_lvl[s]     = 7'(START_DUTY);
         drive_lvl[s]    = 1'b0;
      end
   endfunction

   // Advance the predicted state by one transaction and return its result
   function automatic rsp_type move_step(req_type t);
      rsp_type            r;
      logic               enc  [2];
      logic               warm [2];
      logic [15:0]        goal_r, goal_l;
      logic signed [15:0] steps, slow_idx, bound;
      int                 diff, st, pg, tgt;
      r      = '0;
      enc[0] = t.enc_right;
      enc[1] = t.enc_left;

      if (t.mode == MODE_CMD) begin
         if (moving) begin
            r.drive_right = drive_lvl[0];
            r.drive_left  = drive_lvl[1];
            r.status      = STATUS_RUN;
            return r;
         end
         goal_r = 16'(t.command[19:12]) * 16'd4;
         goal_l = 16'(t.command[7:0]) * 16'd4;
         if (goal_r <= 16'd4 || goal_l <= 16'd4) begin
            r.status = STATUS_REJECT;
            return r;
         end
         pace[0]       = 16'(SPEED_BASE) + 16'(t.command[23:20]) * 16'd8;
         pace[1]       = 16'(SPEED_BASE) + 16'(t.command[11:8]) * 16'd8;
         edges_goal[0] = goal_r;
         edges_goal[1] = goal_l;
         for (int s = 0; s < 2; s++) begin
            enc_seen[s]     = enc[s];
            edges_done[s]   = '0;
            since_edge[s]   = '0;
            last_period[s]  = '0;
            period_delta[s] = '0;
            duty_lvl[s]     = 7'(START_DUTY);
            drive_lvl[s]    = 1'b1;
         end
         phase         = 0;
         moving        = 1'b1;
         r.drive_right = 1'b1;
         r.drive_left  = 1'b1;
         r.status      = STATUS_RUN;
         return r;
      end

      if (!moving) begin
         r.status = STATUS_IDLE;
         return r;
      end

      // Edge detection and interval measurement
      for (int s = 0; s < 2; s++) begin
         if (enc[s] && !enc_seen[s]) begin
            diff            = int'(since_edge[s]) - int'(last_period[s]);
            period_delta[s] = diff[15:0];
            last_period[s]  = since_edge[s];
            since_edge[s]   = '0;
            edges_done[s]   = edges_done[s] + 16'd1;
         end else begin
            since_edge[s] = since_edge[s] + 13'd1;
         end
         enc_seen[s] = enc[s];
         warm[s]     = edges_done[s] >= WARM_EDGES;
      end

      // Slow down over the last steps; all of this wraps at 16 bits signed
      for (int s = 0; s < 2; s++) begin
         diff  = int'(edges_goal[s]) - int'(edges_done[s]);
         steps = diff[15:0];
         if (steps <= SLOW_STEPS) begin
            st       = steps;
            diff     = SLOW_STEPS - st;
            slow_idx = diff[15:0];
            st       = slow_idx;
            diff     = SLOW_BASE + 4 * st;
            bound    = diff[15:0];
            if (bound > pace[s]) pace[s] = bound;
         end
      end

      for (int s = 0; s < 2; s++)
         drive_lvl[s] = (phase < int'(duty_lvl[s])) && (edges_done[s] < edges_goal[s]);

      phase++;
      if (phase >= PERIOD) begin
         for (int s = 0; s < 2; s++) begin
            if (warm[s]) begin
               pg  = pace[s];
               tgt = (pg - int'(last_period[s])) / 4;
               st  = period_delta[s];
               if (st < tgt && duty_lvl[s] > 7'd1) duty_lvl[s] = duty_lvl[s] - 7'd1;
               if (st > tgt && duty_lvl[s] < PERIOD) duty_lvl[s] = duty_lvl[s] + 7'd1;
            end
         end
         phase = 0;
      end

      // A wheel without edges for too long counts as arrived
      for (int s = 0; s < 2; s++) begin
         if (since_edge[s] >= STALL_TICKS) begin
            since_edge[s] = 13'(STALL_TICKS);
            edges_done[s] = edges_goal[s];
         end
      end

      if (edges_done[0] >= edges_goal[0] && edges_done[1] >= edges_goal[1]) begin
         moving       = 1'b0;
         drive_lvl[0] = 1'b0;
         drive_lvl[1] = 1'b0;
         r.status     = STATUS_FIN;
         return r;
      end

      r.drive_right = drive_lvl[0];
      r.drive_left  = drive_lvl[1];
      r.status      = STATUS_RUN;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_motion();
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("rsp transaction with nothing pending: %p", rsp_payload);
               fail_tally++;
            end else begin
               want = due_results.pop_front();
               if (rsp_payload.drive_right !== want.drive_right) begin
                  $error("drive_right: expected %0b, actual %0b",
                         want.drive_right, rsp_payload.drive_right);
                  fail_tally++;
               end
               if (rsp_payload.drive_left !== want.drive_left) begin
                  $error("drive_left: expected %0b, actual %0b",
                         want.drive_left, rsp_payload.drive_left);
                  fail_tally++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
                  fail_tally++;
               end
            end
         end
         if (req_valid && !req_stall)
            due_results.push_back(move_step(req_payload));
      end
      errors      <= fail_tally;
      outstanding <= due_results.size();
   end

endmodule

@@ verif/dual_encoder_motor_pwm_controller_tb.sv @@
// Testbench top for the two-wheel move controller: clock, reset, stimulus, idling, verdict.
// Depends on dempc_pkg, dempc_checker and dual_encoder_motor_pwm_controller.
module dual_encoder_motor_pwm_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dempc_pkg::*;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // calm: suppress idling on both sides for the current sequence
   logic calm  = 1'b0;
   // Encoder levels carried from one transaction to the next
   logic enc_r = 1'b0;
   logic enc_l = 1'b0;

   int errors;
   int outstanding;
   int hold_left = 0;
   int counted   = 0;
   int moves     = 0;

   dual_encoder_motor_pwm_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   dempc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run, long gaps and stalls included
   initial begin
      #2_000_000;
      $display("dual_encoder_motor_pwm_controller test failed");
      $finish;
   end

   // Sender gap: mostly none, sometimes a short gap, rarely a long pause
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Receiver: hold rsp_stall for random stretches, skip it entirely when calm
   always @(posedge clock) begin : rsp_idler
      int r;
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_stall <= 1'b0;
         end else if (r < 94) begin
            rsp_stall <= 1'b1;
            hold_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            hold_left <= $urandom_range(8, 30);
         end
      end
   end

   // Offer one transaction with the current encoder levels and wait until it is taken.
   // Valid stays high on return, so a back-to-back transaction follows without a gap.
   task automatic put_item(input mode_type md, input logic [CMD_W-1:0] cmd);
      int      gap;
      req_type t;
      gap         = pick_gap();
      t.mode      = md;
      t.command   = cmd;
      t.enc_right = enc_r;
      t.enc_left  = enc_l;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Turn both wheels: each encoder toggles every half_* ticks. A rough train adds
   // encoder glitches and stray commands; the command field of ticks is random noise.
   task automatic spin_wheels(input int half_r, input int half_l, input int n_ticks,
                              input bit rough);
      for (int k = 1; k <= n_ticks; k++) begin
         if (k % half_r == 0) enc_r = ~enc_r;
         if (k % half_l == 0) enc_l = ~enc_l;
         if (rough && $urandom_range(0, 99) < 3) enc_r = ~enc_r;
         if (rough && $urandom_range(0, 99) < 3) enc_l = ~enc_l;
         if (rough && $urandom_range(0, 99) < 3)
            put_item(MODE_CMD, {4'($urandom), 8'($urandom_range(2, 5)),
                                4'($urandom), 8'($urandom_range(2, 5))});
         put_item(MODE_TICK, CMD_W'($urandom));
      end
   endtask

   initial begin : stimulus
      int               r, rr, rl, hr, hl, n, k;
      logic [CMD_W-1:0] cmd;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: tick while idle, then commands rejected for a zero or one rotation field
      enc_r = 1'b1;
      enc_l = 1'b1;
      put_item(MODE_TICK, '1);
      put_item(MODE_CMD, 24'h000000);
      put_item(MODE_CMD, 24'hF01FFF);
      put_item(MODE_CMD, 24'hFFFF01);

      // Smallest accepted move, a command that arrives mid-run, then the fastest
      // encoders through slowdown, run end and some idle ticks
      enc_r = 1'b0;
      enc_l = 1'b0;
      put_item(MODE_CMD, 24'h002002);
      put_item(MODE_CMD, 24'hFFFFFF);
      spin_wheels(1, 1, 24, 1'b0);
      counted = 30;

      // Random: mostly complete moves with random speeds and encoder rates, some cut
      // short, plus rejected commands and loose ticks
      while (counted < 450) begin
         calm <= ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 80) begin
            rr    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(2, 5);
            rl    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(2, 5);
            hr    = $urandom_range(1, 4);
            hl    = $urandom_range(1, 4);
            enc_r = $urandom_range(0, 1);
            enc_l = $urandom_range(0, 1);
            cmd   = {4'($urandom), 8'(rr), 4'($urandom), 8'(rl)};
            put_item(MODE_CMD, cmd);
            // Enough ticks for the slower wheel to reach its edge count
            n = ((rr * hr > rl * hl) ? rr * hr : rl * hl) * 8 + $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
            spin_wheels(hr, hl, n, 1'b1);
            counted += n + 1;
            moves++;
         end else if (r < 90) begin
            cmd = CMD_W'($urandom);
            if ($urandom_range(0, 1)) cmd[19:12] = 8'($urandom_range(0, 1));
            else cmd[7:0] = 8'($urandom_range(0, 1));
            enc_r = $urandom_range(0, 1);
            enc_l = $urandom_range(0, 1);
            put_item(MODE_CMD, cmd);
            counted++;
         end else begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) begin
               enc_r = $urandom_range(0, 1);
               enc_l = $urandom_range(0, 1);
               put_item(MODE_TICK, CMD_W'($urandom));
            end
            counted += n;
         end
      end

      // Drain: drop valid, wait for every pending result, then let the bench settle
      req_valid <= 1'b0;
      k = 0;
      do begin
         @(posedge clock);
         k++;
      end while (outstanding != 0 && k < 5000);
      repeat (4) @(posedge clock);

      $display("Sent %0d counted transactions, %0d of them random move commands with tick trains,",
               counted, moves);
      $display("plus rejected and ignored commands, idle ticks and moves cut short mid-run.");
      if (errors == 0 && outstanding == 0) begin
         $display("dual_encoder_motor_pwm_controller test passed");
      end else begin
         $display("dual_encoder_motor_pwm_controller test failed");
      end
      $finish;
   end

endmodule
